// ----- design/elir_pkg.sv -----
// Shared definitions for the edit log index remapper.
// Command and edit kind codes, default sizes and the walk status struct.
// Depends on nothing.
`default_nettype none

package elir_pkg;

  localparam int unsigned LogDepthDef  = 32;
  localparam int unsigned IndexBitsDef = 16;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_UPDATE  = 2'd2,
    KIND_REPLACE = 2'd3
  } kind_e;

  // Outcome of applying one logged edit to the index under walk.
  typedef struct packed {
    logic insert_hit;
    logic update_hit;
  } step_flags_t;

endpackage

`default_nettype wire

// ----- design/edit_log_index_remapper.sv -----
// Channel   | Signals                                             | Handshake
// request   | cmd_i change_kind_i position_i count_i query_index_i | start, busy
// result    | old_index_o is_new_o changed_o                       | done_o strobe
//
// Record and flush requests never raise busy.
// A query on a non-empty log with no replace or overflow flag walks the log
// newest to oldest, one entry per cycle from the single read port of the log
// memory: busy stays high while entries are left (up to LOG_DEPTH of them),
// an insert edit covering the index ends the walk early; done_o pulses in
// the cycle after. Otherwise the result shows in the next cycle.
// Reset clears the flags and the fill count; the log memory is not cleared.
// The receiver cannot stall; done_o marks each result for one cycle only.
// Uses elir_pkg and elir_step.
`default_nettype none

module edit_log_index_remapper
  import elir_pkg::*;
#(
  parameter int unsigned LOG_DEPTH  = LogDepthDef,
  parameter int unsigned INDEX_BITS = IndexBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            cmd_i,
  input  logic [1:0]            change_kind_i,
  input  logic [INDEX_BITS-1:0] position_i,
  input  logic [INDEX_BITS-1:0] count_i,
  input  logic [INDEX_BITS-1:0] query_index_i,
  output logic                  done_o,
  output logic [INDEX_BITS-1:0] old_index_o,
  output logic                  is_new_o,
  output logic                  changed_o
);

  localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned FW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned EW = 2 + 2 * INDEX_BITS;
  localparam logic [FW-1:0] FillFull = FW'(LOG_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e                state_q;
  logic                  replaced_q;
  logic                  overflow_q;
  logic [FW-1:0]         fill_q;
  logic [FW-1:0]         left_q;
  logic [AW-1:0]         ptr_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic                  changed_acc_q;
  logic                  done_q;
  logic [INDEX_BITS-1:0] old_index_q;
  logic                  is_new_q;
  logic                  changed_q;

  logic [EW-1:0]         mem_q [LOG_DEPTH];
  logic [EW-1:0]         rd_data_q;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [FW-1:0]         fill_m1;
  logic [AW-1:0]         ptr_m1;

  logic                  accept;
  logic                  is_record;
  logic                  is_query;
  logic                  is_flush;
  logic                  fast_query;

  kind_e                 ent_kind;
  logic [INDEX_BITS-1:0] ent_pos;
  logic [INDEX_BITS-1:0] ent_cnt;
  logic [INDEX_BITS-1:0] step_index;
  step_flags_t           step_flags;

  assign accept     = start && !busy;
  assign is_record  = accept && (cmd_i == CMD_RECORD);
  assign is_query   = accept && (cmd_i == CMD_QUERY);
  assign is_flush   = accept && (cmd_i == CMD_FLUSH);
  assign fast_query = replaced_q || overflow_q || (fill_q == '0);

  assign wr_en = is_record && !replaced_q && (change_kind_i != KIND_REPLACE)
                 && (fill_q != FillFull);

  // While idle the port already reads the newest entry, so the walk can
  // consume it in the first cycle after the query is taken.
  assign fill_m1 = fill_q - FW'(1);
  assign ptr_m1  = ptr_q - AW'(1);
  assign rd_addr = (state_q == ST_IDLE) ? fill_m1[AW-1:0] : ptr_m1;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[fill_q[AW-1:0]] <= {change_kind_i, position_i, count_i};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign ent_kind = kind_e'(rd_data_q[EW-1 -: 2]);
  assign ent_pos  = rd_data_q[2*INDEX_BITS-1 -: INDEX_BITS];
  assign ent_cnt  = rd_data_q[INDEX_BITS-1:0];

  elir_step #(
    .INDEX_BITS(INDEX_BITS)
  ) u_step (
    .index_i   (idx_q),
    .kind_i    (ent_kind),
    .position_i(ent_pos),
    .count_i   (ent_cnt),
    .index_o   (step_index),
    .flags_o   (step_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      replaced_q    <= 1'b0;
      overflow_q    <= 1'b0;
      fill_q        <= '0;
      left_q        <= '0;
      ptr_q         <= '0;
      idx_q         <= '0;
      changed_acc_q <= 1'b0;
      done_q        <= 1'b0;
      old_index_q   <= '0;
      is_new_q      <= 1'b0;
      changed_q     <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          done_q <= is_query && fast_query;
          if (is_record && !replaced_q) begin
            if (change_kind_i == KIND_REPLACE) begin
              replaced_q <= 1'b1;
              overflow_q <= 1'b0;
              fill_q     <= '0;
            end else if (fill_q == FillFull) begin
              overflow_q <= 1'b1;
            end else begin
              fill_q <= fill_q + FW'(1);
            end
          end
          if (is_flush) begin
            overflow_q <= 1'b0;
            fill_q     <= '0;
          end
          if (is_query) begin
            if (fast_query) begin
              is_new_q    <= replaced_q || overflow_q;
              old_index_q <= (replaced_q || overflow_q) ? '0 : query_index_i;
              changed_q   <= 1'b0;
            end else begin
              state_q       <= ST_WALK;
              left_q        <= fill_q;
              ptr_q         <= fill_m1[AW-1:0];
              idx_q         <= query_index_i;
              changed_acc_q <= 1'b0;
            end
          end
        end
        ST_WALK: begin
          done_q        <= step_flags.insert_hit || (left_q == FW'(1));
          idx_q         <= step_index;
          changed_acc_q <= changed_acc_q || step_flags.update_hit;
          left_q        <= left_q - FW'(1);
          ptr_q         <= ptr_m1;
          if (step_flags.insert_hit) begin
            state_q     <= ST_IDLE;
            is_new_q    <= 1'b1;
            old_index_q <= '0;
            changed_q   <= 1'b0;
          end else if (left_q == FW'(1)) begin
            state_q     <= ST_IDLE;
            is_new_q    <= 1'b0;
            old_index_q <= step_index;
            changed_q   <= changed_acc_q || step_flags.update_hit;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign old_index_o = old_index_q;
  assign is_new_o    = is_new_q;
  assign changed_o   = changed_q;

  // A new item never carries an update mark or a mapped index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && is_new_o |-> !changed_o && (old_index_o == '0))
    else $error("new item reported with update mark or index");

  // A taken query ends in a result or keeps walking.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == CMD_QUERY) |=> done_o || busy)
    else $error("query request produced neither result nor walk");

  // The walk always has entries left to visit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (left_q != '0) && (left_q <= fill_q))
    else $error("walk counter out of range");

  // The fill count never passes the log depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("log fill count above depth");

  // Once set, the replace flag keeps the log empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    replaced_q |-> (fill_q == '0) && !overflow_q)
    else $error("log holds entries after replace");

endmodule

`default_nettype wire

// ----- design/elir_step.sv -----
// One step of the backward index walk: applies a single logged edit.
// Uses elir_pkg for the kind codes and the status struct.
`default_nettype none

module elir_step
  import elir_pkg::*;
#(
  parameter int unsigned INDEX_BITS = IndexBitsDef
) (
  input  logic [INDEX_BITS-1:0] index_i,
  input  kind_e                 kind_i,
  input  logic [INDEX_BITS-1:0] position_i,
  input  logic [INDEX_BITS-1:0] count_i,
  output logic [INDEX_BITS-1:0] index_o,
  output step_flags_t           flags_o
);

  logic [INDEX_BITS:0] end_pos;
  logic [INDEX_BITS:0] sum_idx;
  logic                at_or_above;
  logic                below_end;

  assign end_pos     = {1'b0, position_i} + {1'b0, count_i};
  assign sum_idx     = {1'b0, index_i} + {1'b0, count_i};
  assign at_or_above = (index_i >= position_i);
  assign below_end   = ({1'b0, index_i} < end_pos);

  always_comb begin
    index_o = index_i;
    flags_o = '0;
    case (kind_i)
      KIND_REMOVE: begin
        // Removed elements shift later items down, so add the count back.
        if (at_or_above) begin
          index_o = sum_idx[INDEX_BITS] ? {INDEX_BITS{1'b1}} : sum_idx[INDEX_BITS-1:0];
        end
      end
      KIND_UPDATE: begin
        flags_o.update_hit = at_or_above && below_end;
      end
      KIND_INSERT: begin
        if (!below_end) begin
          index_o = index_i - count_i;
        end else if (at_or_above) begin
          flags_o.insert_hit = 1'b1;
        end
      end
      default: begin
        index_o = index_i;
      end
    endcase
  end

endmodule

`default_nettype wire
